// ----- rtl/first_fit_heap_allocator_top_assert.svh -----
// Assertion macros for the first-fit allocator.
// A_ALWAYS checks a condition at every clock edge outside reset.
// A_NEXT checks that a consequent holds in the cycle after an antecedent.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define A_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define A_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/ffha_pkg.sv -----
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int unsigned HEAP_BYTES   = 1048576;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned SPLIT_SLACK  = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned OFF_W        = 20;
  localparam int unsigned REQ_W        = 21;
  localparam int unsigned SIZE_W       = 22;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_REINIT = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] granted_offset;
  } out_t;

  typedef struct packed {
    logic             is_free;
    logic [OFF_W-1:0] payload;
    logic [OFF_W-1:0] start;
  } entry_t;
endpackage

// ----- rtl/first_fit_heap_allocator_top.sv -----
`timescale 1ns / 1ps
// First-fit heap allocator over a 1 MiB heap, block table of MAX_BLOCKS entries.
// Input channel: in_valid / in_stall / in_data (mode, request_bytes, payload_offset).
// Mode 0 allocates, mode 1 frees, mode 2 restores one free block, mode 3 is a no-op.
// Result channel: out_valid / out_stall / out_data (status, granted_offset); one
// result per accepted request.
// Sequencing: the table sits in one memory with a registered read, walked by one
// compare/add unit. A lookup reads and checks each entry visited in turn; a split
// shifts the entries above the hit up one at a time, a free with merge shifts them
// down one at a time. Reinit, zero size and mode 3 skip the table walk. One request
// is in work at a time; in_stall stays high from acceptance until the result is
// loaded into the output register.
// Reset: after rst_n rises the block writes table entry 0 (the whole heap, free)
// in state S_INIT and then accepts requests; in_stall is high in that state.
// Output stall: the result register holds its transfer while out_stall is high;
// a finished request waits in its final state until the register frees up.
module first_fit_heap_allocator_top
  import ffha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_U_RD, S_U_WR, S_A_W1, S_A_W2,
    S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK, S_F_MRG, S_D_CHK, S_D_RD, S_D_WR
  } state_t;

  localparam logic [OFF_W-1:0]  HDR       = OFF_W'(HEADER_BYTES);
  localparam logic [SIZE_W:0]   SPLIT_ADD = (SIZE_W+1)'(HEADER_BYTES + SPLIT_SLACK);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

  state_t            state_r;
  logic [IDX_W-1:0]  idx_r, hit_r;
  logic [CNT_W-1:0]  j_r, cnt_r;
  logic [1:0]        d_r;
  logic              pf_r, nf_r;
  entry_t            cur_r, prev_r, rd_q;
  logic [OFF_W-1:0]  acc_r, off_r;
  logic [SIZE_W-1:0] size_r;
  logic [1:0]        res_status_r;
  logic [OFF_W-1:0]  res_off_r;
  logic              out_valid_r;
  out_t              out_data_r;

  entry_t mem [MAX_BLOCKS];

  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;

  // Lookup helpers on the freshly read entry.
  logic              is_last, fits, split, match;
  logic [SIZE_W-1:0] size_in;
  logic [IDX_W-1:0]  low_idx;
  logic [CNT_W-1:0]  j_dec;
  logic              drop_more, res_load;

  assign is_last = ({1'b0, idx_r} + CNT_ONE) == cnt_r;
  assign fits    = rd_q.is_free && ({2'b0, rd_q.payload} >= size_r);
  assign split   = ({3'b0, rd_q.payload} >= ({1'b0, size_r} + SPLIT_ADD)) && (cnt_r < CNT_MAX);
  assign match   = ({1'b0, rd_q.start} + {1'b0, HDR}) == {1'b0, off_r};
  assign size_in = (SIZE_W'(in_data.request_bytes) + SIZE_W'(7)) & ~SIZE_W'(7);
  assign low_idx = pf_r ? hit_r - IDX_W'(1) : hit_r;
  assign j_dec   = j_r - CNT_ONE;

  // Load the result once the table is compacted and the output register is free.
  assign drop_more = (j_r + CNT_W'(d_r)) < cnt_r;
  assign res_load  = (state_r == S_D_CHK) && !drop_more && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Table write port: one write per cycle, picked by the sequencer state.
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rd_q;
    case (state_r)
      S_INIT: begin
        we = 1'b1;
        wd = '{is_free: 1'b1, payload: OFF_W'(HEAP_BYTES - HEADER_BYTES), start: '0};
      end
      S_IDLE: begin
        we = in_valid && (in_data.mode == MODE_REINIT);
        wd = '{is_free: 1'b1, payload: OFF_W'(HEAP_BYTES - HEADER_BYTES), start: '0};
      end
      S_A_CHK: begin
        we = fits && !split;
        wa = idx_r;
        wd = '{is_free: 1'b0, payload: rd_q.payload, start: rd_q.start};
      end
      S_U_WR: begin
        we = 1'b1;
        wa = j_r[IDX_W-1:0];
      end
      S_A_W1: begin
        we = 1'b1;
        wa = hit_r + IDX_W'(1);
        wd = '{is_free: 1'b1,
               payload: cur_r.payload - size_r[OFF_W-1:0] - HDR,
               start:   cur_r.start + HDR + size_r[OFF_W-1:0]};
      end
      S_A_W2: begin
        we = 1'b1;
        wa = hit_r;
        wd = '{is_free: 1'b0, payload: size_r[OFF_W-1:0], start: cur_r.start};
      end
      S_F_MRG: begin
        we = 1'b1;
        wa = low_idx;
        wd = '{is_free: 1'b1, payload: acc_r, start: pf_r ? prev_r.start : cur_r.start};
      end
      S_D_WR: begin
        we = 1'b1;
        wa = j_r[IDX_W-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= CNT_ONE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !res_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            size_r       <= size_in;
            off_r        <= in_data.payload_offset;
            res_off_r    <= '0;
            idx_r        <= '0;
            case (in_data.mode)
              MODE_ALLOC: begin
                if (in_data.request_bytes == '0) begin
                  res_status_r <= ST_ZERO;
                  state_r      <= S_D_CHK;
                  j_r          <= cnt_r;
                  d_r          <= '0;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_A_RD;
                end
              end
              MODE_FREE: begin
                res_status_r <= ST_OK;
                state_r      <= S_F_RD;
              end
              default: begin
                // reinit and the spare code both finish at once
                if (in_data.mode == MODE_REINIT) begin
                  cnt_r <= CNT_ONE;
                end
                res_status_r <= ST_OK;
                state_r      <= S_D_CHK;
                j_r          <= cnt_r;
                d_r          <= '0;
              end
            endcase
          end
        end
        S_A_RD: begin
          state_r <= S_A_CHK;
        end
        S_A_CHK: begin
          if (fits) begin
            hit_r     <= idx_r;
            cur_r     <= rd_q;
            res_off_r <= rd_q.start + HDR;
            if (split) begin
              if (is_last) begin
                state_r <= S_A_W1;
              end else begin
                j_r     <= cnt_r;
                idx_r   <= IDX_W'(cnt_r - CNT_ONE);
                state_r <= S_U_RD;
              end
            end else begin
              j_r     <= cnt_r;
              d_r     <= '0;
              state_r <= S_D_CHK;
            end
          end else if (is_last) begin
            res_status_r <= ST_NOFIT;
            j_r          <= cnt_r;
            d_r          <= '0;
            state_r      <= S_D_CHK;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_A_RD;
          end
        end
        S_U_RD: begin
          state_r <= S_U_WR;
        end
        S_U_WR: begin
          // shift one entry up, then step down toward the hit
          j_r <= j_dec;
          if (j_dec > ({1'b0, hit_r} + CNT_ONE)) begin
            idx_r   <= IDX_W'(j_dec - CNT_ONE);
            state_r <= S_U_RD;
          end else begin
            state_r <= S_A_W1;
          end
        end
        S_A_W1: begin
          state_r <= S_A_W2;
        end
        S_A_W2: begin
          cnt_r   <= cnt_r + CNT_ONE;
          j_r     <= cnt_r;
          d_r     <= '0;
          state_r <= S_D_CHK;
        end
        S_F_RD: begin
          state_r <= S_F_CHK;
        end
        S_F_CHK: begin
          if (match) begin
            hit_r <= idx_r;
            cur_r <= rd_q;
            pf_r  <= (idx_r != '0) && prev_r.is_free;
            nf_r  <= 1'b0;
            if ((idx_r != '0) && prev_r.is_free) begin
              acc_r <= prev_r.payload + HDR + rd_q.payload;
            end else begin
              acc_r <= rd_q.payload;
            end
            if (is_last) begin
              state_r <= S_F_MRG;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_F_NRD;
            end
          end else begin
            prev_r <= rd_q;
            if (is_last) begin
              res_status_r <= ST_UNKNOWN;
              j_r          <= cnt_r;
              d_r          <= '0;
              state_r      <= S_D_CHK;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_F_RD;
            end
          end
        end
        S_F_NRD: begin
          state_r <= S_F_NCHK;
        end
        S_F_NCHK: begin
          nf_r <= rd_q.is_free;
          if (rd_q.is_free) begin
            acc_r <= acc_r + HDR + rd_q.payload;
          end
          state_r <= S_F_MRG;
        end
        S_F_MRG: begin
          // merged entry written; drop the absorbed neighbors above it
          j_r     <= {1'b0, low_idx} + CNT_ONE;
          d_r     <= {1'b0, pf_r} + {1'b0, nf_r};
          state_r <= S_D_CHK;
        end
        S_D_CHK: begin
          if (drop_more) begin
            idx_r   <= IDX_W'(j_r + CNT_W'(d_r));
            state_r <= S_D_RD;
          end else if (res_load) begin
            cnt_r                     <= cnt_r - CNT_W'(d_r);
            d_r                       <= '0;
            out_valid_r               <= 1'b1;
            out_data_r.status         <= res_status_r;
            out_data_r.granted_offset <= (res_status_r == ST_OK) ? res_off_r : '0;
            state_r                   <= S_IDLE;
          end
        end
        S_D_RD: begin
          state_r <= S_D_WR;
        end
        S_D_WR: begin
          j_r     <= j_r + CNT_ONE;
          state_r <= S_D_CHK;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`include "first_fit_heap_allocator_top_assert.svh"

  `A_ALWAYS(a_cnt_range, (cnt_r != '0) && (cnt_r <= CNT_MAX), "block count out of range")
  `A_ALWAYS(a_err_zero, !out_valid_r || (out_data_r.status == ST_OK) || (out_data_r.granted_offset == '0), "error result carries an offset")
  `A_NEXT(a_split_grow, state_r == S_A_W2, cnt_r == $past(cnt_r) + CNT_ONE, "split did not grow table")
  `A_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE, "accepted request not started")

endmodule
